/* design/vsa_pkg.sv */
// Package: shared types and constants for the vertex skinning accumulator.
package vsa_pkg;
    typedef enum logic [1:0] {
        CMD_REST  = 2'd0,
        CMD_POSED = 2'd1,
        CMD_ROT   = 2'd2,
        CMD_VERT  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]   cmd;
        logic [7:0]   bone;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] scalar;
        logic         last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic         saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec3_t;

    typedef struct packed {
        vec3_t rest;
        vec3_t posed;
        vec3_t rq;
        logic signed [31:0] rw;
    } bone_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_D, ST_C1, ST_C2, ST_T, ST_E1, ST_E2,
        ST_W, ST_R, ST_P, ST_M, ST_ACC, ST_OUT
    } state_t;

    localparam logic signed [31:0] MAX32 = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;
    localparam logic signed [47:0] MAX48 = 48'sh7FFFFFFFFFFF;
    localparam logic signed [47:0] MIN48 = 48'sh800000000000;

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        if (v > 80'(MAX32)) return MAX32;
        if (v < 80'(MIN32)) return MIN32;
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [79:0] v);
        if (v > 80'(MAX48)) return MAX48;
        if (v < 80'(MIN48)) return MIN48;
        return v[47:0];
    endfunction
endpackage

/* design/vertex_skinning_accumulator_top.sv */
// Top level: linear blend skinning accumulator.
// Load items (rest, posed, rotation) read the table on acceptance, then write
// back the modified bone entry. A contribution steps through the states READ,
// D, C1, C2, T, E1, E2, W, R, P, M and ACC, which follow its chain of dependent
// multiplies, and on the last one of a vertex waits in OUT until the result is
// taken. One item is in work at a time. Bone numbers wrap modulo BONE_SLOTS.
module vertex_skinning_accumulator_top import vsa_pkg::*; #(
    parameter int BONE_SLOTS = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
    vsa_core #(.BONE_SLOTS(BONE_SLOTS), .FRAC_BITS(FRAC_BITS)) u_core (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

/* design/vsa_table.sv */
// Bone table: one synchronous memory, one write and one registered read port.
module vsa_table import vsa_pkg::*; #(
    parameter int BONE_SLOTS = 256
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(BONE_SLOTS)-1:0] waddr,
    input  bone_t                         wdata,
    input  logic [$clog2(BONE_SLOTS)-1:0] raddr,
    output bone_t                         rdata
);
    bone_t mem [BONE_SLOTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/vsa_core.sv */
// Datapath: sequences the rotation, weighting and accumulation of one contribution.
module vsa_core import vsa_pkg::*; #(
    parameter int BONE_SLOTS = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
    localparam int AW = $clog2(BONE_SLOTS);
    localparam logic signed [79:0] HALF = 80'sd1 <<< (FRAC_BITS - 1);

    function automatic logic signed [79:0] rnd(input logic signed [79:0] v);
        return (v + HALF) >>> FRAC_BITS;
    endfunction

    function automatic logic [AW-1:0] wrap_bone(input logic [7:0] b);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = 0; i < 256; i++) begin
            if (b == 8'(i)) idx = AW'(i % BONE_SLOTS);
        end
        return idx;
    endfunction

    state_t state_reg, state_next;
    in_item_t item_reg;
    bone_t    ent_reg;
    vec3_t    d_reg, c_reg, t_reg, e_reg, r_reg;
    logic signed [63:0] pa_reg, pb_reg, pc_reg;
    logic signed [47:0] sx_reg, sy_reg, sz_reg;
    logic               last_reg;

    logic  we;
    bone_t wdata, rdata, bone_w;
    logic [AW-1:0] addr;

    assign addr = s_valid && s_ready ? wrap_bone(s_data.bone) : wrap_bone(item_reg.bone);

    always_comb begin
        wdata = rdata;
        case (cmd_t'(item_reg.cmd))
            CMD_REST:  wdata.rest  = {item_reg.vec_x, item_reg.vec_y, item_reg.vec_z};
            CMD_POSED: wdata.posed = {item_reg.vec_x, item_reg.vec_y, item_reg.vec_z};
            CMD_ROT: begin
                wdata.rq = {item_reg.vec_x, item_reg.vec_y, item_reg.vec_z};
                wdata.rw = item_reg.scalar;
            end
            default: wdata = rdata;
        endcase
    end

    vsa_table #(.BONE_SLOTS(BONE_SLOTS)) u_table (
        .aclk(aclk), .we(we), .waddr(wrap_bone(item_reg.bone)), .wdata(wdata),
        .raddr(addr), .rdata(rdata)
    );

    assign bone_w = ent_reg;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        we = 1'b0;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_READ;
            ST_READ: begin
                if (cmd_t'(item_reg.cmd) == CMD_VERT) begin
                    state_next = ST_D;
                end else begin
                    we = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_D:   state_next = ST_C1;
            ST_C1:  state_next = ST_C2;
            ST_C2:  state_next = ST_T;
            ST_T:   state_next = ST_E1;
            ST_E1:  state_next = ST_E2;
            ST_E2:  state_next = ST_W;
            ST_W:   state_next = ST_R;
            ST_R:   state_next = ST_P;
            ST_P:   state_next = ST_M;
            ST_M:   state_next = ST_ACC;
            ST_ACC: state_next = last_reg ? ST_OUT : ST_IDLE;
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_ACC: begin
                    sx_reg <= sat48(80'(sx_reg) + 80'(sat48(rnd(80'(pa_reg)))));
                    sy_reg <= sat48(80'(sy_reg) + 80'(sat48(rnd(80'(pb_reg)))));
                    sz_reg <= sat48(80'(sz_reg) + 80'(sat48(rnd(80'(pc_reg)))));
                end
                ST_OUT: if (m_ready) begin
                    sx_reg <= '0;
                    sy_reg <= '0;
                    sz_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: if (s_valid) item_reg <= s_data;
            ST_READ: ent_reg <= rdata;
            ST_D: begin
                d_reg.x <= sat32(80'(item_reg.vec_x) - 80'(bone_w.rest.x));
                d_reg.y <= sat32(80'(item_reg.vec_y) - 80'(bone_w.rest.y));
                d_reg.z <= sat32(80'(item_reg.vec_z) - 80'(bone_w.rest.z));
            end
            ST_C1, ST_E1: begin
                pa_reg <= 64'(bone_w.rq.y) * 64'(state_reg == ST_C1 ? d_reg.z : t_reg.z);
                pb_reg <= 64'(bone_w.rq.z) * 64'(state_reg == ST_C1 ? d_reg.x : t_reg.x);
                pc_reg <= 64'(bone_w.rq.x) * 64'(state_reg == ST_C1 ? d_reg.y : t_reg.y);
            end
            ST_C2: begin
                c_reg.x <= sat32(rnd(80'(pa_reg) - 80'(bone_w.rq.z) * 80'(d_reg.y)));
                c_reg.y <= sat32(rnd(80'(pb_reg) - 80'(bone_w.rq.x) * 80'(d_reg.z)));
                c_reg.z <= sat32(rnd(80'(pc_reg) - 80'(bone_w.rq.y) * 80'(d_reg.x)));
            end
            ST_T: begin
                t_reg.x <= sat32(80'(c_reg.x) * 80'sd2);
                t_reg.y <= sat32(80'(c_reg.y) * 80'sd2);
                t_reg.z <= sat32(80'(c_reg.z) * 80'sd2);
            end
            ST_E2: begin
                e_reg.x <= sat32(rnd(80'(pa_reg) - 80'(bone_w.rq.z) * 80'(t_reg.y)));
                e_reg.y <= sat32(rnd(80'(pb_reg) - 80'(bone_w.rq.x) * 80'(t_reg.z)));
                e_reg.z <= sat32(rnd(80'(pc_reg) - 80'(bone_w.rq.y) * 80'(t_reg.x)));
            end
            ST_W: begin
                pa_reg <= 64'(bone_w.rw) * 64'(t_reg.x);
                pb_reg <= 64'(bone_w.rw) * 64'(t_reg.y);
                pc_reg <= 64'(bone_w.rw) * 64'(t_reg.z);
            end
            ST_R: begin
                r_reg.x <= sat32(80'(d_reg.x) + 80'(sat32(rnd(80'(pa_reg)))) + 80'(e_reg.x));
                r_reg.y <= sat32(80'(d_reg.y) + 80'(sat32(rnd(80'(pb_reg)))) + 80'(e_reg.y));
                r_reg.z <= sat32(80'(d_reg.z) + 80'(sat32(rnd(80'(pc_reg)))) + 80'(e_reg.z));
            end
            ST_P: begin
                r_reg.x <= sat32(80'(r_reg.x) + 80'(bone_w.posed.x));
                r_reg.y <= sat32(80'(r_reg.y) + 80'(bone_w.posed.y));
                r_reg.z <= sat32(80'(r_reg.z) + 80'(bone_w.posed.z));
            end
            ST_M: begin
                pa_reg   <= 64'(r_reg.x) * 64'(item_reg.scalar);
                pb_reg   <= 64'(r_reg.y) * 64'(item_reg.scalar);
                pc_reg   <= 64'(r_reg.z) * 64'(item_reg.scalar);
                last_reg <= item_reg.last;
            end
            default: ;
        endcase
    end

    always_comb begin
        m_data.pos_x = sat32(80'(sx_reg));
        m_data.pos_y = sat32(80'(sy_reg));
        m_data.pos_z = sat32(80'(sz_reg));
        m_data.saturated = (80'(sx_reg) != 80'(m_data.pos_x)) ||
                           (80'(sy_reg) != 80'(m_data.pos_y)) ||
                           (80'(sz_reg) != 80'(m_data.pos_z));
    end
endmodule
